>>> rtl/core/fpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the framed packet receiver.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_ID    = 3'd1,
    PH_SIZE  = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4,
    PH_STOP  = 3'd5
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MARKER = 1'b0,
    CFG_STOP_MARKER  = 1'b1
  } cfg_idx_e;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  localparam int unsigned ST_MISMATCH_BIT = 0;
  localparam int unsigned ST_NO_STOP_BIT  = 1;

  typedef struct packed {
    logic               kind;
    logic [ByteW-1:0]   pbyte;
    logic [ByteW-1:0]   pidx;
    logic [ByteW-1:0]   id;
    logic [ByteW-1:0]   size;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

>>> rtl/core/fpr_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_in_stage
// Input register holding one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module fpr_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rx_valid_i,
  output logic                      rx_ready_o,
  input  logic [fpr_pkg::ByteW-1:0] rx_byte_i,
  input  logic                      consume_i,
  output logic                      vld_o,
  output logic [fpr_pkg::ByteW-1:0] byte_o
);
  import fpr_pkg::*;

  logic             vld_q, vld_d;
  logic [ByteW-1:0] byte_q;
  logic             load;

  assign rx_ready_o = !vld_q || consume_i;
  assign load       = rx_valid_i && rx_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (consume_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

>>> rtl/core/fpr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_parser
// Frame state machine, marker registers and result formation.
// ----------------------------------------------------------------------------
module fpr_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fpr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fpr_pkg::ByteW-1:0]   cfg_wdata_i,
  input  logic [fpr_pkg::ByteW-1:0]   byte_i,
  input  logic                        step_i,
  output logic                        has_res_o,
  output fpr_pkg::result_t            res_o
);
  import fpr_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] start_q, stop_q;
  logic [ByteW-1:0] id_q, id_d;
  logic [ByteW-1:0] size_q, size_d;
  logic [ByteW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic             mis_q, mis_d;
  logic [ByteW-1:0] cnt_inc;

  assign cnt_inc = cnt_q + 1'b1;

  // next state
  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    size_d  = size_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    mis_d   = mis_q;
    unique case (phase_q)
      PH_ID: begin
        id_d    = byte_i;
        sum_d   = byte_i;
        phase_d = PH_SIZE;
      end
      PH_SIZE: begin
        size_d  = byte_i;
        sum_d   = sum_q + byte_i;
        cnt_d   = '0;
        phase_d = (byte_i == '0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        cnt_d = cnt_inc;
        if (cnt_inc == size_q) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        mis_d   = (byte_i != sum_q);
        phase_d = PH_STOP;
      end
      PH_STOP: begin
        phase_d = PH_WAIT;
      end
      default: begin
        phase_d = PH_WAIT;
        if (byte_i == start_q) begin
          sum_d   = '0;
          mis_d   = 1'b0;
          cnt_d   = '0;
          phase_d = PH_ID;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    has_res_o  = 1'b0;
    res_o      = '0;
    res_o.id   = id_q;
    res_o.size = size_q;
    unique case (phase_q)
      PH_DATA: begin
        has_res_o   = 1'b1;
        res_o.kind  = KIND_PAYLOAD;
        res_o.pbyte = byte_i;
        res_o.pidx  = cnt_q;
      end
      PH_STOP: begin
        has_res_o                    = 1'b1;
        res_o.kind                   = KIND_REPORT;
        res_o.status[ST_MISMATCH_BIT] = mis_q;
        res_o.status[ST_NO_STOP_BIT]  = (byte_i != stop_q);
      end
      default: begin
        has_res_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      id_q    <= '0;
      size_q  <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      mis_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      size_q  <= size_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      mis_q   <= mis_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      stop_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_MARKER: start_q <= cfg_wdata_i;
        CFG_STOP_MARKER:  stop_q  <= cfg_wdata_i;
        default:          start_q <= start_q;
      endcase
    end
  end

endmodule

>>> rtl/core/fpr_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_out_stage
// Result register holding one item until the sink takes it.
// ----------------------------------------------------------------------------
module fpr_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  fpr_pkg::result_t res_i,
  output logic             free_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output fpr_pkg::result_t res_o
);
  import fpr_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign free_o = !vld_q || res_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (res_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

>>> rtl/core/framed_packet_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_unit
// Parses start, id, size, data, check, stop frames from a byte stream.
//
//   channel   direction  handshake                 payload
//   rx        in         rx_valid_i / rx_ready_o   rx_byte_i
//   res       out        res_valid_o / res_ready_i result_kind_o .. packet_status_o
//   cfg       in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One byte per cycle unless the result register backs up: input register, parse
// logic, result register. A byte leaves its input register in the cycle after
// acceptance unless it makes a result while the result register is full and not
// being taken. Reset clears the frame state, markers and both valid flags.
// ----------------------------------------------------------------------------
module framed_packet_receiver_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fpr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fpr_pkg::ByteW-1:0]   cfg_wdata_i,
  input  logic                        rx_valid_i,
  output logic                        rx_ready_o,
  input  logic [fpr_pkg::ByteW-1:0]   rx_byte_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic                        result_kind_o,
  output logic [fpr_pkg::ByteW-1:0]   payload_byte_o,
  output logic [fpr_pkg::ByteW-1:0]   payload_index_o,
  output logic [fpr_pkg::ByteW-1:0]   packet_id_o,
  output logic [fpr_pkg::ByteW-1:0]   packet_size_o,
  output logic [fpr_pkg::StatusW-1:0] packet_status_o
);
  import fpr_pkg::*;

  logic             in_vld;
  logic [ByteW-1:0] in_byte;
  logic             out_free;
  logic             step_vld;
  logic             step_has_res;
  result_t          res_new, res_out;

  assign step_vld = in_vld && (!step_has_res || out_free);

  fpr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .consume_i  (step_vld),
    .vld_o      (in_vld),
    .byte_o     (in_byte)
  );

  fpr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (in_byte),
    .step_i      (step_vld),
    .has_res_o   (step_has_res),
    .res_o       (res_new)
  );

  fpr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_vld && step_has_res),
    .res_i       (res_new),
    .free_o      (out_free),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .res_o       (res_out)
  );

  assign result_kind_o   = res_out.kind;
  assign payload_byte_o  = res_out.pbyte;
  assign payload_index_o = res_out.pidx;
  assign packet_id_o     = res_out.id;
  assign packet_size_o   = res_out.size;
  assign packet_status_o = res_out.status;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for framed_packet_receiver_unit.
//
// Bytes are pushed into the rx channel with random gaps and the results are
// drained with random stalls. Every byte that the block takes is also run
// through a frame parser kept in the bench, which queues the payload items
// and end-of-packet reports the block should produce. Each result is matched
// field by field against the oldest queued one. A short directed opening is
// followed by random frames, noise and cut-off frames under several marker
// settings, including a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import fpr_pkg::*;

  localparam int unsigned ItemTarget = 650;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles = 250;

  class frame_tracker;
    phase_e           phase;
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] stop_marker;
    logic [ByteW-1:0] frame_id;
    logic [ByteW-1:0] frame_size;
    logic [ByteW-1:0] payload_count;
    logic [ByteW-1:0] running_sum;
    logic             sum_bad;
    result_t          due_results[$];
    int unsigned      errors;

    function new();
      phase         = PH_WAIT;
      start_marker  = '0;
      stop_marker   = '0;
      frame_id      = '0;
      frame_size    = '0;
      payload_count = '0;
      running_sum   = '0;
      sum_bad       = 1'b0;
      errors        = 0;
    endfunction

    function void set_marker(cfg_idx_e idx, logic [ByteW-1:0] value);
      if (idx == CFG_START_MARKER) begin
        start_marker = value;
      end else begin
        stop_marker = value;
      end
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction

    // advance the frame parser by one accepted byte
    function void take_byte(logic [ByteW-1:0] b);
      result_t r;
      r = '0;
      case (phase)
        PH_ID: begin
          frame_id    = b;
          running_sum = b;
          phase       = PH_SIZE;
        end
        PH_SIZE: begin
          frame_size    = b;
          running_sum   = running_sum + b;
          payload_count = '0;
          if (b == '0) begin
            phase = PH_CHECK;
          end else begin
            phase = PH_DATA;
          end
        end
        PH_DATA: begin
          r.kind  = KIND_PAYLOAD;
          r.pbyte = b;
          r.pidx  = payload_count;
          r.id    = frame_id;
          r.size  = frame_size;
          due_results.push_back(r);
          payload_count = payload_count + 1'b1;
          if (payload_count == frame_size) begin
            phase = PH_CHECK;
          end
        end
        PH_CHECK: begin
          sum_bad = (b != running_sum);
          phase   = PH_STOP;
        end
        PH_STOP: begin
          r.kind                    = KIND_REPORT;
          r.id                      = frame_id;
          r.size                    = frame_size;
          r.status[ST_MISMATCH_BIT] = sum_bad;
          r.status[ST_NO_STOP_BIT]  = (b != stop_marker);
          due_results.push_back(r);
          phase = PH_WAIT;
        end
        default: begin
          phase = PH_WAIT;
          if (b == start_marker) begin
            running_sum   = '0;
            sum_bad       = 1'b0;
            payload_count = '0;
            phase         = PH_ID;
          end
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) begin
        report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
      end
    endtask

    task match_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d", got.kind));
      end else begin
        want = due_results.pop_front();
        compare_field("result_kind", got.kind, want.kind);
        compare_field("payload_byte", got.pbyte, want.pbyte);
        compare_field("payload_index", got.pidx, want.pidx);
        compare_field("packet_id", got.id, want.id);
        compare_field("packet_size", got.size, want.size);
        compare_field("packet_status", got.status, want.status);
      end
    endtask

    task flag_leftover();
      if (due_results.size() != 0) begin
        report($sformatf("%0d results never arrived", due_results.size()));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [ByteW-1:0]    cfg_wdata_i = '0;
  logic                rx_valid_i = 1'b0;
  logic                rx_ready_o;
  logic [ByteW-1:0]    rx_byte_i = '0;
  logic                res_valid_o;
  logic                res_ready_i = 1'b0;
  logic                result_kind_o;
  logic [ByteW-1:0]    payload_byte_o;
  logic [ByteW-1:0]    payload_index_o;
  logic [ByteW-1:0]    packet_id_o;
  logic [ByteW-1:0]    packet_size_o;
  logic [StatusW-1:0]  packet_status_o;

  frame_tracker        tracker = new();
  int unsigned         cycles = 0;
  int unsigned         sent = 0;
  bit                  tx_quiet = 1'b0;
  bit                  rx_quiet = 1'b0;
  bit                  hold_go = 1'b0;
  logic [ByteW-1:0]    start_mk = '0;
  logic [ByteW-1:0]    stop_mk = '0;

  framed_packet_receiver_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .result_kind_o  (result_kind_o),
    .payload_byte_o (payload_byte_o),
    .payload_index_o(payload_index_o),
    .packet_id_o    (packet_id_o),
    .packet_size_o  (packet_size_o),
    .packet_status_o(packet_status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rx_valid_i && rx_ready_o) begin
      tracker.take_byte(rx_byte_i);
    end
    if (rst_ni && res_valid_o && res_ready_i) begin
      tracker.match_result({result_kind_o, payload_byte_o, payload_index_o,
                            packet_id_o, packet_size_o, packet_status_o});
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_go) begin
        res_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_go = 1'b0;
      end
      stall = rx_quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        res_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ready_i <= 1'b1;
      do @(posedge clk_i); while (!res_valid_o);
    end
  end

  task send_byte(logic [ByteW-1:0] b);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    sent++;
  endtask

  task send_frame(logic [ByteW-1:0] id, logic [ByteW-1:0] size, bit check_ok,
                  bit stop_ok);
    logic [ByteW-1:0] sum;
    sum = id + size;
    send_byte(start_mk);
    send_byte(id);
    send_byte(size);
    for (int i = 0; i < size; i++) begin
      send_byte(ByteW'($urandom_range(0, 255)));
    end
    send_byte(check_ok ? sum : sum + ByteW'($urandom_range(1, 255)));
    send_byte(stop_ok ? stop_mk : stop_mk + ByteW'($urandom_range(1, 255)));
  endtask

  // let the block run dry before touching the markers
  task settle();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task program_markers(logic [ByteW-1:0] start_v, logic [ByteW-1:0] stop_v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_START_MARKER;
    cfg_wdata_i <= start_v;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_STOP_MARKER;
    cfg_wdata_i <= stop_v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_marker(CFG_START_MARKER, start_v);
    tracker.set_marker(CFG_STOP_MARKER, stop_v);
    start_mk = start_v;
    stop_mk  = stop_v;
  endtask

  initial begin
    int unsigned      round;
    int unsigned      round_end;
    int unsigned      roll;
    logic [ByteW-1:0] size;
    round = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset markers: stray bytes, extreme id, size zero with both faults
    send_byte(8'hFF); send_byte(8'h5A);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h02);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h01); send_byte(8'h00);
    send_byte(8'h00); send_byte(8'h80); send_byte(8'h00);
    send_byte(8'h7F); send_byte(8'hAA);
    settle();

    // markers inside frame content, then check mismatch only
    program_markers(8'h7E, 8'h7F);
    send_byte(8'h7E); send_byte(8'h7E); send_byte(8'h01);
    send_byte(8'h7F); send_byte(8'h7F); send_byte(8'h7F);
    send_byte(8'h7E); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h01); send_byte(8'h7F);

    while (sent < ItemTarget) begin
      settle();
      case (round)
        0: program_markers(8'h00, 8'hFF);
        1: program_markers(8'hFF, 8'h00);
        2: program_markers(8'hFF, 8'hFF);
        default: program_markers(ByteW'($urandom_range(0, 255)),
                                 ByteW'($urandom_range(0, 255)));
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (round == 1) begin
        // receiver stops for a long stretch while bytes keep coming
        hold_go  = 1'b1;
        tx_quiet = 1'b1;
        send_frame(ByteW'($urandom_range(0, 255)), 8'd48, 1'b1, 1'b1);
        tx_quiet = 1'b0;
      end
      if (round == 3) begin
        send_frame(ByteW'($urandom_range(0, 255)), 8'd255, 1'b1, 1'b1);
      end
      round_end = sent + 90;
      while (sent < round_end && sent < ItemTarget) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          repeat ($urandom_range(1, 5)) send_byte(ByteW'($urandom_range(0, 255)));
        end else if (roll < 14) begin
          send_byte(start_mk);
          repeat ($urandom_range(0, 3)) send_byte(ByteW'($urandom_range(0, 255)));
        end else begin
          size = ($urandom_range(0, 9) == 0) ? ByteW'($urandom_range(9, 40)) :
                                               ByteW'($urandom_range(0, 6));
          send_frame(ByteW'($urandom_range(0, 255)), size,
                     $urandom_range(0, 99) < 80, $urandom_range(0, 99) < 80);
        end
      end
      round++;
    end

    settle();
    tracker.flag_leftover();
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
